/* hw/rtl/tci_pkg.sv */
// Shared types, constants and helpers for the tty canonical input queue.
// No dependencies; imported by every module of the block.
package tci_pkg;

  localparam int QUEUE_LEN = 256;
  localparam int PTR_W     = $clog2(QUEUE_LEN);

  localparam logic [7:0] NL_CODE   = 8'h0A;
  localparam logic [7:0] CR_CODE   = 8'h0D;
  localparam logic [7:0] MASK7     = 8'h7F;
  localparam logic [7:0] UPPER_LO  = 8'h41;
  localparam logic [7:0] UPPER_HI  = 8'h5A;
  localparam logic [7:0] LOWER_LO  = 8'h61;

  localparam logic [3:0] INFL_RST  = 4'd5;
  localparam logic [3:0] LOFL_RST  = 4'd7;
  localparam logic [7:0] ERASE_RST = 8'd8;
  localparam logic [7:0] EOL_RST   = 8'd10;

  typedef enum logic [1:0] {
    CFG_INPUT_FLAGS = 2'd0,
    CFG_LOCAL_FLAGS = 2'd1,
    CFG_ERASE_CHAR  = 2'd2,
    CFG_EOL_CHAR    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_char;
  } tci_in_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       wake_reader;
    logic       read_valid;
    logic [7:0] read_char;
    logic       queue_empty;
    logic       line_ready;
    logic       overflow;
  } tci_out_t;

  typedef struct packed {
    logic       is_read;
    logic       is_erase;
    logic       do_echo;
    logic       wake_ok;
    logic [7:0] ch;
  } tci_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_LAST
  } back_state_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_LEN - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    ptr_prev = (p == '0) ? PTR_W'(QUEUE_LEN - 1) : p - PTR_W'(1);
  endfunction

endpackage

/* hw/rtl/tci_front.sv */
// Front end: configuration registers, character transform and classification.
// Depends on tci_pkg.
module tci_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [7:0]       cfg_wdata,
  input  tci_pkg::tci_in_t in_data,
  output tci_pkg::tci_cmd_t cmd,
  output logic [7:0]       eol_char
);
  import tci_pkg::*;

  logic [3:0] infl_r;
  logic [3:0] lofl_r;
  logic [7:0] erase_r;
  logic [7:0] eol_r;
  logic [7:0] c0;
  logic [7:0] c1;
  logic [7:0] c2;
  logic       canon;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infl_r  <= INFL_RST;
      lofl_r  <= LOFL_RST;
      erase_r <= ERASE_RST;
      eol_r   <= EOL_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_INPUT_FLAGS: infl_r  <= cfg_wdata[3:0];
        CFG_LOCAL_FLAGS: lofl_r  <= cfg_wdata[3:0];
        CFG_ERASE_CHAR:  erase_r <= cfg_wdata;
        CFG_EOL_CHAR:    eol_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    c0 = infl_r[0] ? (in_data.rx_char & MASK7) : in_data.rx_char;
    if (c0 == NL_CODE && infl_r[1]) begin
      c1 = CR_CODE;
    end else if (c0 == CR_CODE && infl_r[2]) begin
      c1 = NL_CODE;
    end else begin
      c1 = c0;
    end
    if (infl_r[3] && c1 >= UPPER_LO && c1 <= UPPER_HI) begin
      c2 = c1 - UPPER_LO + LOWER_LO;
    end else begin
      c2 = c1;
    end
  end

  assign canon        = lofl_r[0];
  assign cmd.is_read  = in_data.req_type;
  assign cmd.is_erase = canon && lofl_r[2] && (c2 == erase_r);
  assign cmd.do_echo  = lofl_r[1] || (lofl_r[3] && c2 == NL_CODE);
  assign cmd.wake_ok  = !canon || c2 == NL_CODE || c2 == eol_r;
  assign cmd.ch       = c2;
  assign eol_char     = eol_r;

endmodule

/* hw/rtl/tci_cmd_fifo.sv */
// Two-entry command queue between front end and ring back end.
// Depends on tci_pkg.
module tci_cmd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tci_pkg::tci_cmd_t  din,
  input  logic               pop,
  output tci_pkg::tci_cmd_t  dout,
  output logic               empty,
  output logic               full
);
  import tci_pkg::*;

  tci_cmd_t   ent_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* hw/rtl/tci_back.sv */
// Back end: character ring memory, head/tail pointers, result register.
// Depends on tci_pkg.
module tci_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  tci_pkg::tci_cmd_t cmd,
  input  logic [7:0]        eol_char,
  output logic              cmd_pop,
  output logic              out_valid,
  output tci_pkg::tci_out_t out_data
);
  import tci_pkg::*;

  logic [7:0]       mem [QUEUE_LEN];
  logic [7:0]       rd_data_r;
  logic [PTR_W-1:0] rd_addr;
  logic             wr_en;

  back_state_t      state_r;
  back_state_t      state_nxt;
  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] head_nxt;
  logic [PTR_W-1:0] tail_r;
  logic [PTR_W-1:0] tail_nxt;
  logic [7:0]       last_r;
  logic [7:0]       last_nxt;
  tci_cmd_t         hold_r;
  tci_cmd_t         hold_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  tci_out_t         out_data_r;
  tci_out_t         out_data_nxt;

  logic             ring_empty;
  logic             ring_full;
  logic [PTR_W-1:0] tail_inc;
  logic [PTR_W-1:0] tail_dec;
  logic [PTR_W-1:0] tail_dec2;
  logic [PTR_W-1:0] head_inc;

  function automatic logic line_end(input logic [7:0] c, input logic [7:0] eol);
    line_end = (c == NL_CODE) || (c == eol);
  endfunction

  assign ring_empty = (head_r == tail_r);
  assign tail_inc   = ptr_next(tail_r);
  assign tail_dec   = ptr_prev(tail_r);
  assign tail_dec2  = ptr_prev(tail_dec);
  assign head_inc   = ptr_next(head_r);
  assign ring_full  = (tail_inc == head_r);
  assign cmd_pop    = (state_r == BK_IDLE) && cmd_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_read && !ring_empty) begin
            state_nxt = BK_POP;
          end else if (!cmd.is_read && cmd.is_erase && !ring_empty && tail_dec != head_r) begin
            state_nxt = BK_LAST;
          end
        end
      end
      BK_POP:  state_nxt = BK_IDLE;
      BK_LAST: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    last_nxt      = last_r;
    hold_nxt      = hold_r;
    wr_en         = 1'b0;
    rd_addr       = head_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          hold_nxt = cmd;
          if (cmd.is_read) begin
            if (ring_empty) begin
              out_valid_nxt            = 1'b1;
              out_data_nxt.queue_empty = 1'b1;
            end
          end else if (cmd.is_erase) begin
            if (ring_empty) begin
              out_valid_nxt            = 1'b1;
              out_data_nxt.queue_empty = 1'b1;
            end else begin
              tail_nxt = tail_dec;
              if (tail_dec == head_r) begin
                out_valid_nxt            = 1'b1;
                out_data_nxt.echo_valid  = cmd.do_echo;
                out_data_nxt.echo_char   = cmd.do_echo ? cmd.ch : '0;
                out_data_nxt.queue_empty = 1'b1;
              end else begin
                rd_addr = tail_dec2;
              end
            end
          end else if (ring_full) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.overflow   = 1'b1;
            out_data_nxt.line_ready = line_end(last_r, eol_char);
          end else begin
            wr_en                    = 1'b1;
            tail_nxt                 = tail_inc;
            last_nxt                 = cmd.ch;
            out_valid_nxt            = 1'b1;
            out_data_nxt.echo_valid  = cmd.do_echo;
            out_data_nxt.echo_char   = cmd.do_echo ? cmd.ch : '0;
            out_data_nxt.wake_reader = cmd.wake_ok;
            out_data_nxt.line_ready  = line_end(cmd.ch, eol_char);
          end
        end
      end
      BK_POP: begin
        head_nxt                 = head_inc;
        out_valid_nxt            = 1'b1;
        out_data_nxt.read_valid  = 1'b1;
        out_data_nxt.read_char   = rd_data_r;
        out_data_nxt.queue_empty = (head_inc == tail_r);
        out_data_nxt.line_ready  = (head_inc != tail_r) && line_end(last_r, eol_char);
      end
      BK_LAST: begin
        last_nxt                = rd_data_r;
        out_valid_nxt           = 1'b1;
        out_data_nxt.echo_valid = hold_r.do_echo;
        out_data_nxt.echo_char  = hold_r.do_echo ? hold_r.ch : '0;
        out_data_nxt.line_ready = line_end(rd_data_r, eol_char);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= cmd.ch;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/tty_canonical_input_queue.sv */
// Top level of the tty canonical input queue: front end, command queue, ring back end.
// Depends on tci_pkg, tci_front, tci_cmd_fifo, tci_back.
// Results pass the command queue and the back-end result register; a read or an erase
// that needs the ring memory read port also passes the ring read data register.
// The queue takes one item per cycle unless busy; the back end pops only when idle.
// Reset (rst_n low, synchronous): ring empty, registers to defaults, busy high.
module tty_canonical_input_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tci_pkg::tci_in_t  in_data,
  output logic              out_valid,
  output tci_pkg::tci_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [7:0]        cfg_wdata
);
  import tci_pkg::*;

  tci_cmd_t   front_cmd;
  tci_cmd_t   q_cmd;
  logic [7:0] eol_char;
  logic       q_empty;
  logic       q_full;
  logic       q_pop;

  assign busy = q_full || !rst_n;

  tci_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (front_cmd),
    .eol_char  (eol_char)
  );

  tci_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (start && !busy),
    .din   (front_cmd),
    .pop   (q_pop),
    .dout  (q_cmd),
    .empty (q_empty),
    .full  (q_full)
  );

  tci_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_cmd),
    .eol_char  (eol_char),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/tci_checker.sv */
// Port-level checks for the tty canonical input queue, bound to the top level.
// Depends on tci_pkg and tty_canonical_input_queue.
module tci_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input tci_pkg::tci_out_t out_data
);
  import tci_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

  a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      !out_data.echo_valid && !out_data.wake_reader && !out_data.queue_empty)
    else $error("overflow item with echo, wake or empty queue");

  a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |->
      !out_data.echo_valid && !out_data.wake_reader && !out_data.overflow)
    else $error("read item with receive side effects");

  a_empty_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.queue_empty |-> !out_data.line_ready && !out_data.wake_reader)
    else $error("line ready or wake on empty queue");

endmodule

bind tty_canonical_input_queue tci_checker u_chk (.*);
